@@ hdl/periodic_timer_table_defines.svh @@
// Assertion macros used by the checker file.
`ifndef PERIODIC_TIMER_TABLE_DEFINES_SVH
`define PERIODIC_TIMER_TABLE_DEFINES_SVH
// Assert that a property holds at every clock edge outside reset.
`define PTT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property also during reset.
`define PTT_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

@@ hdl/ptt_pkg.sv @@
// ---------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the periodic timer table
// Opcodes, result kinds, sequencer states and field widths.
// ---------------------------------------------------------------------------
package ptt_pkg;
    localparam int TIMER_SLOTS_DEF = 16;
    localparam int ID_W   = 32;
    localparam int TIME_W = 62;
    localparam int DL_W   = 63;

    localparam logic [2:0] OP_ADD    = 3'd0;
    localparam logic [2:0] OP_MODIFY = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_TICK   = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    localparam logic [2:0] K_ADDED    = 3'd0;
    localparam logic [2:0] K_FULL     = 3'd1;
    localparam logic [2:0] K_MODIFIED = 3'd2;
    localparam logic [2:0] K_NOTFOUND = 3'd3;
    localparam logic [2:0] K_REMOVED  = 3'd4;
    localparam logic [2:0] K_FIRED    = 3'd5;
    localparam logic [2:0] K_TICKDONE = 3'd6;
    localparam logic [2:0] K_NEXT     = 3'd7;

    localparam logic [DL_W-1:0] DL_EMPTY = {DL_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_EMIT,
        ST_DONE
    } state_t;

    // Slot record held in the slot memory.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] interval;
        logic [DL_W-1:0]   deadline;
        logic              policy;
        logic              notify;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);
endpackage

@@ hdl/ptt_ram.sv @@
// ---------------------------------------------------------------------------
// ptt_ram: generic single-port RAM
// One read per cycle and a write at the same address when we is set, read data registered.
// ---------------------------------------------------------------------------
module ptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

@@ hdl/periodic_timer_table.sv @@
// ---------------------------------------------------------------------------
// periodic_timer_table: fixed table of periodic timers
// Add, modify, remove, tick and query over a slot memory scanned in turn.
// ---------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  request | in        | in_valid/in_ready   | operation .. now
//  result  | out       | out_valid/out_ready | kind, result_id, deadline, last
//
// A request scans the slots one at a time through a shared 63-bit adder: each
// slot is read, then evaluated with write back; the request is accepted in the
// idle state and each result takes an emit step. A tick ends with a tick done
// result. Add, modify and remove stop at the slot that decides them. An unused
// opcode runs the whole scan and returns nothing. Each result waits in the
// output register, and the scan stalls while that register is still full.
// Reset clears the active bits and the id counter at once; there is no
// clearing pass.
module periodic_timer_table
    import ptt_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        operation,
    input  logic [ID_W-1:0]   timer_id,
    input  logic [TIME_W-1:0] interval,
    input  logic [TIME_W-1:0] base_time,
    input  logic              base_valid,
    input  logic              policy,
    input  logic              has_handler,
    input  logic [TIME_W-1:0] now,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        kind,
    output logic [ID_W-1:0]   result_id,
    output logic [DL_W-1:0]   deadline,
    output logic              last
);
    localparam int IDX_W = $clog2(TIMER_SLOTS > 1 ? TIMER_SLOTS : 2);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

    state_t state_reg, state_next;

    logic [TIMER_SLOTS-1:0] active_reg, active_next;
    logic [ID_W-1:0]   id_counter_reg, id_counter_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [DL_W-1:0]   soonest_reg, soonest_next;

    logic [2:0]        op_reg;
    logic [ID_W-1:0]   tid_reg;
    logic [TIME_W-1:0] interval_reg, now_reg, start_reg;
    logic              policy_reg, notify_reg;

    // Result decided in evaluate, waiting for the output register.
    logic [2:0]        pkind_reg, pkind_next;
    logic [ID_W-1:0]   pid_reg, pid_next;
    logic [DL_W-1:0]   pdl_reg, pdl_next;
    logic              plast_reg, plast_next;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        kind_reg, kind_next;
    logic [ID_W-1:0]   rid_reg, rid_next;
    logic [DL_W-1:0]   dl_reg, dl_next;
    logic              last_reg, last_next;

    logic              ram_we;
    slot_t             ram_wdata, ram_rdata;

    logic [DL_W-1:0]   add_a, add_b, add_sum, rearm_now, rearm_phase;
    logic              cur_active, due, matched, is_last, out_free, emit;

    ptt_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TIMER_SLOTS)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .addr (idx_reg),
        .wdata(ram_wdata),
        .rdata(ram_rdata)
    );

    assign cur_active = active_reg[idx_reg];
    assign matched = cur_active && (ram_rdata.id == tid_reg);
    assign is_last = (idx_reg == LAST_IDX);
    assign out_free = !out_valid_reg || out_ready;
    assign due = ram_rdata.deadline <= {1'b0, now_reg};

    // Shared adder: start + interval for add and modify, deadline + interval
    // for a tick. A due deadline is not after now, so the sum stays in 63 bits.
    always_comb
    begin
        if (op_reg == OP_TICK)
        begin
            add_a = ram_rdata.deadline;
            add_b = {1'b0, ram_rdata.interval};
        end
        else
        begin
            add_a = {1'b0, start_reg};
            add_b = {1'b0, interval_reg};
        end
    end
    assign add_sum = add_a + add_b;
    assign rearm_now = {1'b0, now_reg} + {1'b0, ram_rdata.interval};
    assign rearm_phase = (add_sum <= {1'b0, now_reg}) ? rearm_now : add_sum;

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:               emit = !cur_active || is_last;
            OP_MODIFY, OP_REMOVE: emit = matched || is_last;
            OP_TICK:              emit = cur_active && due && ram_rdata.notify;
            OP_QUERY:             emit = is_last;
            default:              emit = 1'b0;
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_READ;
            ST_READ: state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (emit)
                    state_next = ST_EMIT;
                else if (!is_last)
                    state_next = ST_READ;
                else if (op_reg == OP_TICK)
                    state_next = ST_DONE;
                else
                    state_next = ST_IDLE;
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    if (plast_reg)
                        state_next = ST_IDLE;
                    else if (is_last)
                        state_next = ST_DONE;
                    else
                        state_next = ST_READ;
                end
            end
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        id_counter_next = id_counter_reg;
        idx_next = idx_reg;
        soonest_next = soonest_reg;
        pkind_next = pkind_reg;
        pid_next = pid_reg;
        pdl_next = pdl_reg;
        plast_next = plast_reg;
        out_valid_next = out_valid_reg;
        kind_next = kind_reg;
        rid_next = rid_reg;
        dl_next = dl_reg;
        last_next = last_reg;
        ram_we = 1'b0;
        ram_wdata = ram_rdata;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    idx_next = '0;
                    soonest_next = DL_EMPTY;
                end
            end
            ST_READ:
            begin
            end
            ST_EVAL:
            begin
                pid_next = '0;
                pdl_next = '0;
                plast_next = 1'b1;
                unique case (op_reg)
                    OP_ADD:
                    begin
                        if (!cur_active)
                        begin
                            id_counter_next = id_counter_reg + 1'b1;
                            ram_we = 1'b1;
                            ram_wdata.id = id_counter_next;
                            ram_wdata.interval = interval_reg;
                            ram_wdata.deadline = add_sum;
                            ram_wdata.policy = policy_reg;
                            ram_wdata.notify = notify_reg;
                            active_next[idx_reg] = 1'b1;
                            pkind_next = K_ADDED;
                            pid_next = id_counter_next;
                        end
                        else
                        begin
                            pkind_next = K_FULL;
                        end
                    end
                    OP_MODIFY:
                    begin
                        if (matched)
                        begin
                            ram_we = 1'b1;
                            ram_wdata.interval = interval_reg;
                            ram_wdata.deadline = add_sum;
                            ram_wdata.policy = policy_reg;
                            pkind_next = K_MODIFIED;
                            pid_next = tid_reg;
                        end
                        else
                        begin
                            pkind_next = K_NOTFOUND;
                        end
                    end
                    OP_REMOVE:
                    begin
                        if (matched)
                        begin
                            active_next[idx_reg] = 1'b0;
                            pkind_next = K_REMOVED;
                            pid_next = tid_reg;
                        end
                        else
                        begin
                            pkind_next = K_NOTFOUND;
                        end
                    end
                    OP_TICK:
                    begin
                        pkind_next = K_FIRED;
                        pid_next = ram_rdata.id;
                        plast_next = 1'b0;
                        if (cur_active && due)
                        begin
                            ram_we = 1'b1;
                            ram_wdata.deadline = ram_rdata.policy ? rearm_phase : rearm_now;
                        end
                    end
                    OP_QUERY:
                    begin
                        if (cur_active && ram_rdata.deadline < soonest_reg)
                        begin
                            soonest_next = ram_rdata.deadline;
                        end
                        pkind_next = K_NEXT;
                        pdl_next = soonest_next;
                    end
                    default:
                    begin
                    end
                endcase
                if (!emit && !is_last)
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next = pkind_reg;
                    rid_next = pid_reg;
                    dl_next = pdl_reg;
                    last_next = plast_reg;
                    if (!plast_reg && !is_last)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE:
            begin
                // A tick always ends with tick done, even when nothing fired.
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_next = K_TICKDONE;
                    rid_next = '0;
                    dl_next = '0;
                    last_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            active_reg <= '0;
            id_counter_reg <= '0;
            out_valid_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            active_reg <= active_next;
            id_counter_reg <= id_counter_next;
            out_valid_reg <= out_valid_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        soonest_reg <= soonest_next;
        pkind_reg <= pkind_next;
        pid_reg <= pid_next;
        pdl_reg <= pdl_next;
        plast_reg <= plast_next;
        kind_reg <= kind_next;
        rid_reg <= rid_next;
        dl_reg <= dl_next;
        last_reg <= last_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            op_reg <= operation;
            tid_reg <= timer_id;
            interval_reg <= interval;
            start_reg <= base_valid ? base_time : now;
            now_reg <= now;
            policy_reg <= policy;
            notify_reg <= has_handler;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind = kind_reg;
    assign result_id = rid_reg;
    assign deadline = dl_reg;
    assign last = last_reg;
endmodule

@@ hdl/ptt_checker.sv @@
// ---------------------------------------------------------------------------
// ptt_checker: port-level checks of the periodic timer table
// Watches the request and result handshakes of the top level.
// ---------------------------------------------------------------------------
`include "periodic_timer_table_defines.svh"
module ptt_checker
    import ptt_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] kind,
    input logic       last
);
    `PTT_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(kind), "result dropped while stalled")
    `PTT_ASSERT(a_busy, clk, rst_n, in_valid && in_ready |=> !in_ready, "request accepted while busy")
    `PTT_ASSERT(a_last_kind, clk, rst_n, out_valid && kind != K_FIRED |-> last, "non-fired result without last")
    `PTT_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_valid || rst_n, "result during reset")
endmodule

bind periodic_timer_table ptt_checker u_ptt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind     (kind),
    .last     (last)
);
